// ===== rtl/core/msfd_pkg.sv =====
// Shared types and constants for the sync frame deframer.
`timescale 1ns / 1ps

package msfd_pkg;

  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned HdrIdxW     = 3;

  // register file indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd78;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd68;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_ABORT = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_TOOLONG = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  cmd;
    logic [7:0]  flags;
    logic [7:0]  seq;
    logic [15:0] length;
    logic [7:0]  data;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/msfd_cfg.sv =====
// Configuration registers of the sync frame deframer.
`timescale 1ns / 1ps

module msfd_cfg import msfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata_i[7:0];
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata_i[7:0];
        CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/msfd_parse.sv =====
// Frame parser: sync hunt, header collection and payload counting.
`timescale 1ns / 1ps

module msfd_parse import msfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       take_i,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output result_t    res_o,
  output logic       in_frame_o
);

  localparam logic [1:0] PH_HUNT1   = 2'd0;
  localparam logic [1:0] PH_HUNT2   = 2'd1;
  localparam logic [1:0] PH_HEADER  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [HdrIdxW-1:0] HdrLast = HdrIdxW'(HeaderBytes - 1);
  localparam logic [HdrIdxW-1:0] IdxCmd  = HdrIdxW'(1);
  localparam logic [HdrIdxW-1:0] IdxFlg  = HdrIdxW'(2);
  localparam logic [HdrIdxW-1:0] IdxSeq  = HdrIdxW'(3);
  localparam logic [HdrIdxW-1:0] IdxLenH = HdrIdxW'(4);

  logic [1:0]         phase_q, phase_d;
  logic [HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic [7:0]         cmd_q, cmd_d, flags_q, flags_d, seq_q, seq_d, len_hi_q, len_hi_d;
  logic [15:0]        frame_len_q, frame_len_d, pay_cnt_q, pay_cnt_d;

  logic [15:0] hdr_len;
  logic [15:0] cnt_inc;
  kind_e       kind;
  logic [7:0]  data;
  logic        last;

  assign hdr_len = {len_hi_q, rx_byte_i};
  assign cnt_inc = pay_cnt_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    cmd_d       = cmd_q;
    flags_d     = flags_q;
    seq_d       = seq_q;
    len_hi_d    = len_hi_q;
    frame_len_d = frame_len_q;
    pay_cnt_d   = pay_cnt_q;
    res_valid_o = 1'b0;
    kind        = KIND_HEADER;
    data        = 8'd0;
    last        = 1'b0;

    if (req_type_i == REQ_ABORT) begin
      phase_d   = PH_HUNT1;
      hdr_idx_d = '0;
      if (phase_q == PH_HEADER || phase_q == PH_PAYLOAD) begin
        res_valid_o = 1'b1;
        kind        = KIND_ABORT;
        last        = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == cfg_i.sync_first) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          // second sync byte wins over a repeated first one
          if (rx_byte_i == cfg_i.sync_second) begin
            phase_d     = PH_HEADER;
            hdr_idx_d   = '0;
            cmd_d       = 8'd0;
            flags_d     = 8'd0;
            seq_d       = 8'd0;
            len_hi_d    = 8'd0;
            frame_len_d = 16'd0;
          end else if (rx_byte_i != cfg_i.sync_first) begin
            phase_d = PH_HUNT1;
          end
        end
        PH_HEADER: begin
          case (hdr_idx_q)
            IdxCmd:  cmd_d    = rx_byte_i;
            IdxFlg:  flags_d  = rx_byte_i;
            IdxSeq:  seq_d    = rx_byte_i;
            IdxLenH: len_hi_d = rx_byte_i;
            default: ;
          endcase
          if (hdr_idx_q != HdrLast) begin
            hdr_idx_d = hdr_idx_q + HdrIdxW'(1);
          end else begin
            hdr_idx_d   = '0;
            frame_len_d = hdr_len;
            res_valid_o = 1'b1;
            if (hdr_len > cfg_i.max_payload) begin
              phase_d = PH_HUNT1;
              kind    = KIND_TOOLONG;
              last    = 1'b1;
            end else if (hdr_len == 16'd0) begin
              phase_d = PH_HUNT1;
              last    = 1'b1;
            end else begin
              pay_cnt_d = 16'd0;
              phase_d   = PH_PAYLOAD;
            end
          end
        end
        default: begin
          pay_cnt_d   = cnt_inc;
          res_valid_o = 1'b1;
          kind        = KIND_DATA;
          data        = rx_byte_i;
          if (cnt_inc == frame_len_q) begin
            phase_d = PH_HUNT1;
            last    = 1'b1;
          end
        end
      endcase
    end
  end

  assign res_o.kind   = kind;
  assign res_o.cmd    = cmd_d;
  assign res_o.flags  = flags_d;
  assign res_o.seq    = seq_d;
  assign res_o.length = frame_len_d;
  assign res_o.data   = data;
  assign res_o.last   = last;

  assign in_frame_o = phase_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT1;
      hdr_idx_q   <= '0;
      cmd_q       <= 8'd0;
      flags_q     <= 8'd0;
      seq_q       <= 8'd0;
      len_hi_q    <= 8'd0;
      frame_len_q <= 16'd0;
      pay_cnt_q   <= 16'd0;
    end else if (take_i) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      cmd_q       <= cmd_d;
      flags_q     <= flags_d;
      seq_q       <= seq_d;
      len_hi_q    <= len_hi_d;
      frame_len_q <= frame_len_d;
      pay_cnt_q   <= pay_cnt_d;
    end
  end

endmodule

// ===== rtl/core/msfd_out.sv =====
// Result register with valid/ready handshake toward the receiver.
`timescale 1ns / 1ps

module msfd_out import msfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    free_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // slot frees up when the held word is taken in the same cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/magic_sync_frame_deframer.sv =====
// Top level of the sync frame deframer.
//
// Input channel: in_valid_i/in_ready_o carry one word per handshake, either
// a received byte (req_type_i = 0, value on rx_byte_i) or an abort request
// (req_type_i = 1). Output channel: out_valid_o/out_ready_i carry result
// words: header done, payload byte, length too large, or aborted.
// Each input word yields zero or one result word. A result is registered
// and appears on the output in the cycle after its input word is accepted.
// One input word can be accepted every cycle; the single result register
// sets the throughput, and in_ready_o stays high while that register is
// empty or being drained. If the receiver stalls, the held result waits
// and in_ready_o drops until it is taken, so nothing is lost.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at
// cfg_index_i (0 sync_first, 1 sync_second, 2 max_payload);
// other indexes are ignored. Write only while the block is idle.
// Reset returns the parser to hunting for the first sync byte, empties the
// result register and loads the default sync bytes and payload limit.
`timescale 1ns / 1ps

module magic_sync_frame_deframer import msfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  cmd_o,
  output logic [7:0]  flags_o,
  output logic [7:0]  seq_o,
  output logic [15:0] length_o,
  output logic [7:0]  data_o,
  output logic        last_o
);

  cfg_t    cfg;
  result_t res, res_q;
  logic    take, res_valid, free, in_frame;

  assign in_ready_o = free;
  assign take       = in_valid_i && free;

  msfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  msfd_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .take_i     (take),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res),
    .in_frame_o (in_frame)
  );

  msfd_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take && res_valid),
    .res_i      (res),
    .out_ready_i(out_ready_i),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .res_o      (res_q)
  );

  assign kind_o   = res_q.kind;
  assign cmd_o    = res_q.cmd;
  assign flags_o  = res_q.flags;
  assign seq_o    = res_q.seq;
  assign length_o = res_q.length;
  assign data_o   = res_q.data;
  assign last_o   = res_q.last;

  // an abort always leaves the parser hunting
  a_abort_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && req_type_i == REQ_ABORT |=> !in_frame)
    else $error("abort did not return parser to hunt");

  // the closing word of a frame ends the frame
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && res_valid && res.last |=> !in_frame)
    else $error("parser still in frame after last word");

  // a header that opens a payload carries a nonzero length
  a_open_header_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HEADER && !last_o |-> length_o != 16'd0)
    else $error("open header with zero length");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_TOOLONG || kind_o == KIND_ABORT) |-> last_o)
    else $error("error or abort word without last");

endmodule
